// ===== hw/rtl/fsps_pkg.sv =====
package fsps_pkg;

   // default table depth
   localparam int PROC_MAX_DEF = 16;

   // field widths
   localparam int DUR_W    = 16;
   localparam int WGT_W    = 4;
   localparam int TIME_W   = 32;
   localparam int DTOT_W   = 20;
   localparam int WTOT_W   = 8;
   localparam int SLICE_W  = 24;
   localparam int QUANT_W  = 16;
   localparam int PID_W    = 4;
   localparam int STAT_W   = 2;
   localparam int DIVCNT_W = 5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_QUANTUM = 1'b0;
   localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd100;

   // command codes
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   // one time unit in 24.8
   localparam logic [TIME_W-1:0] ONE_TICK = 32'd256;

   // one table entry
   typedef struct packed {
      logic [DUR_W-1:0]  dur;
      logic [WGT_W-1:0]  wgt;
      logic [TIME_W-1:0] ela;
      logic [TIME_W-1:0] vrt;
      logic [TIME_W-1:0] stp;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic req_load;
      logic add_exec;
      logic scan_issue;
      logic adv_calc;
      logic apply;
      logic div_start;
      logic div_step;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_step;
      logic table_full;
      logic scan_last;
      logic found;
      logic will_finish;
      logic div_last;
      logic out_busy;
   } dp_stat_type;

   // saturating 32-bit add
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/fsps_req_if.sv =====
interface fsps_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] burst_time;
   logic [3:0]  priority_req;

   modport source (output valid, output command, output burst_time, output priority_req,
                   input ready);
   modport sink (input valid, input command, input burst_time, input priority_req,
                 output ready);
endinterface

// ===== hw/rtl/fsps_rsp_if.sv =====
interface fsps_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [3:0]         proc_id;
   logic [31:0]        sched_clock;
   logic               completed;
   logic               all_done;
   logic signed [31:0] switch_overhead;

   modport source (output valid, output status, output proc_id, output sched_clock,
                   output completed, output all_done, output switch_overhead,
                   input ready);
   modport sink (input valid, input status, input proc_id, input sched_clock,
                 input completed, input all_done, input switch_overhead,
                 output ready);
endinterface

// ===== hw/rtl/fair_share_process_scheduler.sv =====
// Add word: latch, table write, bit-serial slice divide (not on a full table), result load.
// Step word: latch, table scan, advance, apply, slice divide if the process finishes, result load.
// One word at a time; the table scan reads one entry per cycle and the slice divider is
// bit-serial. A waiting result does not block the scan.
// Reset (synchronous, active high): empty table, clock and totals zero, quantum 100.
module fair_share_process_scheduler #(
   parameter int MAX_PROCS = fsps_pkg::PROC_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   fsps_req_if.sink   req_chan,
   fsps_rsp_if.source rsp_chan,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [fsps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fsps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fsps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import fsps_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type st;

   assign csr_pready = 1'b1;

   // sequencer
   fsps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // table, scan, divider and result register
   fsps_dpath #(.MAX_PROCS(MAX_PROCS)) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_command         (req_chan.command),
      .req_burst_time      (req_chan.burst_time),
      .req_priority_req    (req_chan.priority_req),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_status          (rsp_chan.status),
      .rsp_proc_id         (rsp_chan.proc_id),
      .rsp_sched_clock     (rsp_chan.sched_clock),
      .rsp_completed       (rsp_chan.completed),
      .rsp_all_done        (rsp_chan.all_done),
      .rsp_switch_overhead (rsp_chan.switch_overhead),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .cmd                 (cmd),
      .st                  (st)
   );

endmodule

// ===== hw/rtl/fsps_ctrl.sv =====
module fsps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fsps_pkg::dp_stat_type st,
   output fsps_pkg::dp_cmd_type  cmd
);
   import fsps_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ADD      = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_SCAN_END = 3'd3;
   localparam logic [2:0] S_EXEC     = 3'd4;
   localparam logic [2:0] S_APPLY    = 3'd5;
   localparam logic [2:0] S_DIV      = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       fire;

   assign req_ready = (state_ff == S_IDLE);
   assign fire      = req_valid && req_ready;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (fire) begin
               cmd.req_load = 1'b1;
               state_in     = st.is_step ? S_SCAN : S_ADD;
            end
         end
         S_ADD: begin
            cmd.add_exec = 1'b1;
            if (st.table_full) begin
               state_in = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (st.scan_last) state_in = S_SCAN_END;
         end
         S_SCAN_END: state_in = S_EXEC;
         S_EXEC: begin
            cmd.adv_calc = 1'b1;
            state_in     = st.found ? S_APPLY : S_FINISH;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            if (st.will_finish) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!st.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/fsps_dpath.sv =====
module fsps_dpath #(
   parameter int MAX_PROCS = fsps_pkg::PROC_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // input word
   input  logic                 req_command,
   input  logic [15:0]          req_burst_time,
   input  logic [3:0]           req_priority_req,
   // result word
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [3:0]           rsp_proc_id,
   output logic [31:0]          rsp_sched_clock,
   output logic                 rsp_completed,
   output logic                 rsp_all_done,
   output logic signed [31:0]   rsp_switch_overhead,
   // register port
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [fsps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fsps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fsps_pkg::CSR_DATA_W-1:0] csr_prdata,
   // control
   input  fsps_pkg::dp_cmd_type  cmd,
   output fsps_pkg::dp_stat_type st
);
   import fsps_pkg::*;

   localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);

   // registers
   logic [QUANT_W-1:0] quantum_ff;
   logic [DUR_W-1:0]   burst_ff;
   logic [WGT_W-1:0]   wgt_req_ff;
   logic [MAX_PROCS-1:0] live_ff;
   logic [TIME_W-1:0]  stamp_ff;
   logic [TIME_W-1:0]  clock_ff;
   logic [DTOT_W-1:0]  dtot_ff;
   logic [WTOT_W-1:0]  wtot_ff;
   logic [SLICE_W-1:0] slice_ff;
   logic [CW-1:0]      live_cnt_ff;
   logic [CW-1:0]      next_id_ff;
   logic [IW-1:0]      scan_idx_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic               rd_pend_ff;
   logic               rd_live_ff;
   entry_type          rd_ff;
   logic               best_vld_ff;
   logic [IW-1:0]      best_id_ff;
   entry_type          best_ff;
   logic [TIME_W-1:0]  adv_ff;
   logic [TIME_W-1:0]  full_ff;
   logic [WTOT_W-1:0]  rem_ff;
   logic [SLICE_W-1:0] dq_ff;
   logic [DIVCNT_W-1:0] div_cnt_ff;
   logic               div_ran_ff;
   logic [STAT_W-1:0]  res_stat_ff;
   logic [PID_W-1:0]   res_pid_ff;
   logic               res_done_ff;
   logic               res_all_ff;
   logic [TIME_W-1:0]  res_ovh_ff;
   logic               out_vld_ff;
   logic [STAT_W-1:0]  out_stat_ff;
   logic [PID_W-1:0]   out_pid_ff;
   logic [TIME_W-1:0]  out_clk_ff;
   logic               out_done_ff;
   logic               out_all_ff;
   logic [TIME_W-1:0]  out_ovh_ff;

   entry_type mem [MAX_PROCS];

   // combinational helpers
   logic               mem_we;
   logic [IW-1:0]      mem_wa;
   entry_type          mem_wd;
   logic               take;
   logic [WGT_W-1:0]   wgt_eff;
   logic [WTOT_W:0]    wsum;
   logic [DTOT_W:0]    dsum;
   logic [TIME_W-1:0]  full_c;
   logic [TIME_W-1:0]  rem_c;
   logic [TIME_W-1:0]  slice_ext;
   logic [TIME_W-1:0]  adv_c;
   logic [TIME_W-1:0]  ela_new;
   logic [TIME_W-1:0]  vrt_new;
   logic [TIME_W-1:0]  clk_new;
   logic [WTOT_W:0]    trial;
   logic               ge;
   logic [SLICE_W-1:0] slice_c;

   assign wgt_eff  = (wgt_req_ff == '0) ? WGT_W'(1) : wgt_req_ff;
   assign wsum     = {1'b0, wtot_ff} + (WTOT_W+1)'(wgt_eff);
   assign dsum     = {1'b0, dtot_ff} + (DTOT_W+1)'(burst_ff);
   assign full_c   = {8'd0, best_ff.dur, 8'd0};
   assign rem_c    = (best_ff.ela < full_c) ? full_c - best_ff.ela : '0;
   assign slice_ext = TIME_W'(slice_ff);
   assign adv_c    = ({4'd0, quantum_ff} >= dtot_ff) ? ONE_TICK :
                     ((rem_c > slice_ext) ? slice_ext : rem_c);
   assign ela_new  = sat_add(best_ff.ela, adv_ff);
   assign vrt_new  = sat_add(best_ff.vrt, TIME_W'(best_ff.wgt));
   assign clk_new  = sat_add(clock_ff, adv_ff);
   assign trial    = {rem_ff, dq_ff[SLICE_W-1]};
   assign ge       = trial >= {1'b0, wtot_ff};
   assign slice_c  = (wtot_ff == '0) ? '0 : ((dq_ff == '0) ? SLICE_W'(1) : dq_ff);

   // scan compare: least vruntime, then oldest stamp
   assign take = rd_pend_ff && rd_live_ff &&
                 (!best_vld_ff || (rd_ff.vrt < best_ff.vrt) ||
                  ((rd_ff.vrt == best_ff.vrt) && (rd_ff.stp < best_ff.stp)));

   // status to controller
   assign st.is_step     = (req_command == CMD_STEP);
   assign st.table_full  = (next_id_ff >= CW'(MAX_PROCS));
   assign st.scan_last   = (scan_idx_ff == IW'(MAX_PROCS - 1));
   assign st.found       = best_vld_ff;
   assign st.will_finish = (ela_new >= full_ff);
   assign st.div_last    = (div_cnt_ff == DIVCNT_W'(SLICE_W - 1));
   assign st.out_busy    = out_vld_ff && !rsp_ready;

   // table write port
   always_comb begin
      mem_we = 1'b0;
      mem_wa = best_id_ff;
      mem_wd = best_ff;
      if (cmd.add_exec && !st.table_full) begin
         mem_we     = 1'b1;
         mem_wa     = next_id_ff[IW-1:0];
         mem_wd.dur = burst_ff;
         mem_wd.wgt = wgt_eff;
         mem_wd.ela = '0;
         mem_wd.vrt = TIME_W'(wgt_eff);
         mem_wd.stp = stamp_ff;
      end else if (cmd.apply) begin
         mem_we     = 1'b1;
         mem_wd.ela = ela_new;
         mem_wd.vrt = vrt_new;
         mem_wd.stp = stamp_ff;
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[scan_idx_ff];
   end

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RST;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[CSR_ADDR_W-1] == REG_QUANTUM)) begin
         quantum_ff <= csr_pwdata[QUANT_W-1:0];
      end
   end
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_QUANTUM) ?
                       CSR_DATA_W'(quantum_ff) : '0;

   // input word latch
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         burst_ff   <= req_burst_time;
         wgt_req_ff <= req_priority_req;
      end
   end

   // scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         stamp_ff    <= '0;
         clock_ff    <= '0;
         dtot_ff     <= '0;
         wtot_ff     <= '0;
         slice_ff    <= '0;
         live_cnt_ff <= '0;
         next_id_ff  <= '0;
         div_ran_ff  <= 1'b0;
      end else begin
         if (cmd.add_exec && !st.table_full) begin
            live_ff[next_id_ff[IW-1:0]] <= 1'b1;
            stamp_ff    <= stamp_ff + 1'b1;
            live_cnt_ff <= live_cnt_ff + 1'b1;
            next_id_ff  <= next_id_ff + 1'b1;
            dtot_ff     <= dsum[DTOT_W] ? '1 : dsum[DTOT_W-1:0];
            wtot_ff     <= wsum[WTOT_W] ? '1 : wsum[WTOT_W-1:0];
         end
         if (cmd.apply) begin
            clock_ff <= clk_new;
            stamp_ff <= stamp_ff + 1'b1;
            if (st.will_finish) begin
               live_ff[best_id_ff] <= 1'b0;
               if (live_cnt_ff != '0) live_cnt_ff <= live_cnt_ff - 1'b1;
               wtot_ff <= (wtot_ff >= WTOT_W'(best_ff.wgt)) ?
                          wtot_ff - WTOT_W'(best_ff.wgt) : '0;
            end
         end
         if (cmd.div_start) div_ran_ff <= 1'b1;
         if (cmd.out_load) begin
            div_ran_ff <= 1'b0;
            if (div_ran_ff) slice_ff <= slice_c;
         end
      end
   end

   // minimum scan, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff  <= 1'b0;
         best_vld_ff <= 1'b0;
         scan_idx_ff <= '0;
      end else begin
         rd_pend_ff <= cmd.scan_issue;
         if (cmd.req_load) begin
            scan_idx_ff <= '0;
            best_vld_ff <= 1'b0;
         end else if (cmd.scan_issue) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (take) best_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         rd_idx_ff  <= scan_idx_ff;
         rd_live_ff <= live_ff[scan_idx_ff];
      end
      if (take) begin
         best_ff    <= rd_ff;
         best_id_ff <= rd_idx_ff;
      end
      if (cmd.adv_calc) begin
         adv_ff  <= adv_c;
         full_ff <= full_c;
      end
   end

   // slice divider: quantum*256 / weight total, one bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff     <= '0;
         dq_ff      <= {quantum_ff, 8'd0};
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= ge ? WTOT_W'(trial - {1'b0, wtot_ff}) : trial[WTOT_W-1:0];
         dq_ff      <= {dq_ff[SLICE_W-2:0], ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // pending result fields
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         res_stat_ff <= STAT_OK;
         res_pid_ff  <= '0;
         res_done_ff <= 1'b0;
         res_all_ff  <= 1'b0;
         res_ovh_ff  <= '0;
      end else begin
         if (cmd.add_exec) begin
            if (st.table_full) res_stat_ff <= STAT_FULL;
            else               res_pid_ff  <= PID_W'(next_id_ff);
         end
         if (cmd.adv_calc && !best_vld_ff) res_stat_ff <= STAT_EMPTY;
         if (cmd.apply) begin
            res_pid_ff  <= PID_W'(best_id_ff);
            res_done_ff <= st.will_finish;
            if (st.will_finish && (live_cnt_ff == CW'(1))) begin
               res_all_ff <= 1'b1;
               res_ovh_ff <= clk_new - {4'd0, dtot_ff, 8'd0};
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_stat_ff <= res_stat_ff;
         out_pid_ff  <= res_pid_ff;
         out_clk_ff  <= clock_ff;
         out_done_ff <= res_done_ff;
         out_all_ff  <= res_all_ff;
         out_ovh_ff  <= res_ovh_ff;
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_status          = out_stat_ff;
   assign rsp_proc_id         = out_pid_ff;
   assign rsp_sched_clock     = out_clk_ff;
   assign rsp_completed       = out_done_ff;
   assign rsp_all_done        = out_all_ff;
   assign rsp_switch_overhead = signed'(out_ovh_ff);

endmodule

// ===== hw/rtl/fsps_checker.sv =====
module fsps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_proc_id,
   input logic        rsp_completed,
   input logic        rsp_all_done
);
   import fsps_pkg::*;

   // no undefined status code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK) || (rsp_status == STAT_FULL) ||
                    (rsp_status == STAT_EMPTY))
      else $error("bad status code");

   // last process finishing implies this one finished
   a_all_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_done |-> rsp_completed)
      else $error("all_done without completed");

   // error results carry no id and no completion
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> (rsp_proc_id == '0) && !rsp_completed)
      else $error("error word carries payload");

   // stalled word stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("word dropped while stalled");

endmodule

bind fair_share_process_scheduler fsps_checker u_fsps_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_proc_id    (rsp_chan.proc_id),
   .rsp_completed  (rsp_chan.completed),
   .rsp_all_done   (rsp_chan.all_done)
);

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fsps_pkg::*;

   localparam int SLOTS       = PROC_MAX_DEF;
   localparam int CYCLE_LIMIT = 2000000;

   // one expected result word
   typedef struct {
      logic [STAT_W-1:0] status;
      logic [PID_W-1:0]  pid;
      logic [31:0]       fclk;
      logic              done;
      logic              all;
      logic [31:0]       ovh;
   } sched_result_type;

   // predicts the scheduler and holds the words it still owes
   class sched_scoreboard;
      logic [DUR_W-1:0]  dur   [SLOTS];
      logic [WGT_W-1:0]  wgt   [SLOTS];
      logic [31:0]       ela   [SLOTS];
      logic [31:0]       vrt   [SLOTS];
      logic [31:0]       stamp [SLOTS];
      bit                live  [SLOTS];
      logic [31:0]       next_stamp = 0;
      logic [31:0]       fair_clk = 0;
      logic [DTOT_W-1:0] dur_tot = 0;
      logic [WTOT_W-1:0] wgt_tot = 0;
      logic [31:0]       slice = 0;
      int                live_n = 0;
      int                next_slot = 0;
      logic [15:0]       quantum = QUANTUM_RST;
      sched_result_type  owed[$];
      int                errors = 0;
      int                n_add = 0, n_step = 0, n_done = 0, n_all = 0, n_full = 0, n_empty = 0;

      function logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
         logic [32:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      function void new_slice();
         if (wgt_tot == 0) begin
            slice = 0;
         end else begin
            slice = {8'h0, quantum, 8'h0} / {24'h0, wgt_tot};
            if (slice == 0) slice = 1;
         end
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      // note an accepted input word and queue what it should produce
      function void note_word(logic cmd, logic [15:0] burst, logic [3:0] prio);
         sched_result_type r;
         int best;
         logic [31:0] full, adv, rem;
         logic [3:0] w;
         r = '{STAT_OK, 0, 0, 0, 0, 0};
         if (cmd == CMD_ADD) begin
            n_add++;
            if (next_slot >= SLOTS) begin
               r.status = STAT_FULL;
               n_full++;
            end else begin
               w = (prio == 0) ? 4'd1 : prio;
               dur[next_slot]   = burst;
               wgt[next_slot]   = w;
               ela[next_slot]   = 0;
               vrt[next_slot]   = {28'h0, w};
               stamp[next_slot] = next_stamp;
               next_stamp++;
               live[next_slot] = 1;
               live_n++;
               dur_tot = dur_tot + burst;
               wgt_tot = wgt_tot + w;
               new_slice();
               r.pid = next_slot[3:0];
               next_slot++;
            end
         end else begin
            n_step++;
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (live[i] && (best < 0 || vrt[i] < vrt[best] ||
                   (vrt[i] == vrt[best] && stamp[i] < stamp[best])))
                  best = i;
            end
            if (best < 0) begin
               r.status = STAT_EMPTY;
               n_empty++;
            end else begin
               full = {8'h0, dur[best], 8'h0};
               if ({4'h0, quantum} >= dur_tot) begin
                  adv = ONE_TICK;
               end else begin
                  rem = (ela[best] < full) ? full - ela[best] : 0;
                  adv = (rem > slice) ? slice : rem;
               end
               fair_clk    = sat32(fair_clk, adv);
               ela[best]   = sat32(ela[best], adv);
               vrt[best]   = sat32(vrt[best], {28'h0, wgt[best]});
               stamp[best] = next_stamp;
               next_stamp++;
               r.pid = best[3:0];
               if (ela[best] >= full) begin
                  r.done = 1;
                  n_done++;
                  live[best] = 0;
                  live_n--;
                  wgt_tot = (wgt_tot >= wgt[best]) ? wgt_tot - wgt[best] : 0;
                  new_slice();
                  if (live_n == 0) begin
                     r.all = 1;
                     n_all++;
                     r.ovh = fair_clk - {4'h0, dur_tot, 8'h0};
                  end
               end
            end
         end
         r.fclk = fair_clk;
         owed.insert(owed.size(), r);
      endfunction

      // compare one result word against the oldest expectation
      task check_word(logic [1:0] st, logic [3:0] pid, logic [31:0] fclk,
                      logic done, logic all, logic [31:0] ovh);
         sched_result_type e;
         if (owed.size() == 0) begin
            report("result word with nothing expected");
         end else begin
            e = owed.pop_front();
            if (st !== e.status) report($sformatf("status %0d exp %0d", st, e.status));
            if (pid !== e.pid) report($sformatf("proc_id %0d exp %0d", pid, e.pid));
            if (fclk !== e.fclk) report($sformatf("sched_clock %h exp %h", fclk, e.fclk));
            if (done !== e.done) report($sformatf("completed %b exp %b", done, e.done));
            if (all !== e.all) report($sformatf("all_done %b exp %b", all, e.all));
            if (ovh !== e.ovh) report($sformatf("switch_overhead %h exp %h", ovh, e.ovh));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   fsps_req_if req_if ();
   fsps_rsp_if rsp_if ();

   sched_scoreboard sb = new;
   int idle_pct = 0;
   int rsp_stall = 0;
   int cycles = 0;

   fair_share_process_scheduler i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // result side: check accepted words, stall ready in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_word(rsp_if.status, rsp_if.proc_id, rsp_if.sched_clock,
                          rsp_if.completed, rsp_if.all_done, rsp_if.switch_overhead);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall = $urandom_range(1, 18) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // one input word, with an optional idle burst ahead of it
   task automatic send_word(input logic cmd, input logic [15:0] burst, input logic [3:0] prio);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 18);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.command      <= cmd;
      req_if.burst_time   <= burst;
      req_if.priority_req <= prio;
      do @(posedge clock); while (!req_if.ready);
      sb.note_word(cmd, burst, prio);
   endtask

   task automatic step_word();
      send_word(CMD_STEP, 16'($urandom), 4'($urandom));
   endtask

   // stop sending until every owed word has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.owed.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [15:0] q);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(REG_QUANTUM));
      csr_pwdata  <= {16'h0, q};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.quantum = q;
   endtask

   initial begin
      logic [15:0] b;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.command      <= CMD_ADD;
      req_if.burst_time   <= '0;
      req_if.priority_req <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, zero weight, zero duration, run to all done
      idle_pct = 10;
      step_word();
      send_word(CMD_ADD, 16'd0, 4'd0);
      send_word(CMD_ADD, 16'd2, 4'd15);
      send_word(CMD_ADD, 16'd1, 4'd1);
      repeat (8) step_word();
      drain();

      // random segments under several quantum settings
      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0: write_quantum(16'd1);
            1: write_quantum(16'd65535);
            default: write_quantum(16'($urandom_range(1, 2000)));
         endcase
         idle_pct = (seg % 3 == 0) ? 0 : ((seg % 3 == 1) ? 5 : 25);
         for (int k = 0; k < 230; k++) begin
            if (sb.next_slot < SLOTS - 1 && $urandom_range(0, 99) < 6) begin
               b = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60));
               send_word(CMD_ADD, b, 4'($urandom_range(0, 15)));
            end else begin
               step_word();
            end
         end
         drain();
      end

      // final part, no idling: huge quantum, longest burst, then a full table
      idle_pct = 0;
      write_quantum(16'd65535);
      while (sb.next_slot < SLOTS)
         send_word(CMD_ADD, 16'd65535, 4'd1);
      repeat (40) step_word();
      send_word(CMD_ADD, 16'd5, 4'd3);
      step_word();
      drain();

      $display("covered %0d adds (%0d on a full table), %0d steps (%0d on an empty table)",
               sb.n_add, sb.n_full, sb.n_step, sb.n_empty);
      $display("processes finished %0d, whole table drained %0d times, mismatches %0d",
               sb.n_done, sb.n_all, sb.errors);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
